// ===== hdl/event_slot_scheduler_core_macros.svh =====
// Assertion macros for the checker file.
`ifndef EVENT_SLOT_SCHEDULER_CORE_MACROS_SVH
`define EVENT_SLOT_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ESS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ess assertion failed");

// Next-cycle implication, disabled in reset.
`define ESS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ess assertion failed");

// Implication after a fixed number of cycles, disabled in reset.
`define ESS_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error("ess assertion failed");

`endif

// ===== hdl/ess_pkg.sv =====
package ess_pkg;

  localparam int unsigned NumSlotsDef = 16;
  localparam int unsigned TimeBitsDef = 48;

  localparam int unsigned ActionW   = 2;
  localparam int unsigned SlotIdW   = 4;
  localparam int unsigned TimeFldW  = 48;
  localparam int unsigned IntervalW = 32;
  localparam int unsigned StatusW   = 2;

  localparam logic [ActionW-1:0] ActAdd    = 2'd0;
  localparam logic [ActionW-1:0] ActChange = 2'd1;
  localparam logic [ActionW-1:0] ActRetire = 2'd2;
  localparam logic [ActionW-1:0] ActQuery  = 2'd3;

  localparam logic [StatusW-1:0] StsOk      = 2'd0;
  localparam logic [StatusW-1:0] StsFull    = 2'd1;
  localparam logic [StatusW-1:0] StsInvalid = 2'd2;

endpackage

// ===== hdl/ess_cell.sv =====
module ess_cell #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic                 valid_i,
  input  logic [TIME_BITS-1:0] time_i,
  output logic                 valid_o,
  output logic [TIME_BITS-1:0] time_o
);

  logic                 valid_q;
  logic [TIME_BITS-1:0] time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      time_q <= time_i;
    end
  end

  assign valid_o = valid_q;
  assign time_o  = time_q;

endmodule

// ===== hdl/event_slot_scheduler_core.sv =====
// A command is taken only while idle. The StScan state then rotates the slot ring one
// position per cycle past a single head processor, and the StFinish state registers the
// result onto the result strobe and outputs; busy stays high until then, so a new command
// cannot be taken before the previous one is finished.
// The result strobe cycle already accepts the next command; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) frees every slot and drops any command in flight.
module event_slot_scheduler_core #(
  parameter int unsigned NUM_SLOTS = ess_pkg::NumSlotsDef,
  parameter int unsigned TIME_BITS = ess_pkg::TimeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [ess_pkg::ActionW-1:0]    action_i,
  input  logic [ess_pkg::SlotIdW-1:0]    slot_id_i,
  input  logic [ess_pkg::TimeFldW-1:0]   event_time_i,
  input  logic [ess_pkg::IntervalW-1:0]  repeat_interval_i,
  input  logic [ess_pkg::TimeFldW-1:0]   deadline_i,
  output logic                           done_o,
  output logic [ess_pkg::SlotIdW-1:0]    result_slot_o,
  output logic [ess_pkg::TimeFldW-1:0]   result_time_o,
  output logic                           found_o,
  output logic [ess_pkg::StatusW-1:0]    status_o
);

  import ess_pkg::*;

  localparam int unsigned SlotW = $clog2(NUM_SLOTS);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [SlotW-1:0]     cnt_q, cnt_d;
  logic                 hit_q, hit_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [TIME_BITS-1:0] rtime_q, rtime_d;

  logic [ActionW-1:0]   act_q;
  logic [SlotIdW-1:0]   sid_q;
  logic [TIME_BITS-1:0] etime_q;
  logic [IntervalW-1:0] intv_q;
  logic [TIME_BITS-1:0] dl_q;

  logic                 done_q, done_d;
  logic [SlotIdW-1:0]   rslot_q, rslot_d;
  logic [TimeFldW-1:0]  rtout_q, rtout_d;
  logic                 found_q, found_d;
  logic [StatusW-1:0]   sts_q, sts_d;

  logic                 accept;
  logic                 shift;
  logic                 wb_valid;
  logic [TIME_BITS-1:0] wb_time;
  logic                 id_match;
  logic [TIME_BITS-1:0] intv_t;
  logic [TIME_BITS-1:0] sum_t;

  logic [TIME_BITS+TimeFldW-1:0]  etime_ext;
  logic [TIME_BITS+TimeFldW-1:0]  dl_ext;
  logic [TIME_BITS+IntervalW-1:0] intv_ext;
  logic [TIME_BITS+TimeFldW-1:0]  rtime_ext;
  logic [SlotW+SlotIdW-1:0]       slot_ext;

  logic [NUM_SLOTS-1:0] cell_valid;
  logic [TIME_BITS-1:0] cell_time [NUM_SLOTS];

  assign accept = start && (state_q == StIdle);
  assign shift  = (state_q == StScan);

  assign etime_ext = {{TIME_BITS{1'b0}}, event_time_i};
  assign dl_ext    = {{TIME_BITS{1'b0}}, deadline_i};
  assign intv_ext  = {{TIME_BITS{1'b0}}, intv_q};
  assign intv_t    = intv_ext[TIME_BITS-1:0];
  assign sum_t     = cell_time[0] + intv_t;
  assign id_match  = ({{SlotW{1'b0}}, sid_q} == {{SlotIdW{1'b0}}, cnt_q});
  assign rtime_ext = {{TimeFldW{1'b0}}, rtime_q};
  assign slot_ext  = {{SlotIdW{1'b0}}, slot_q};

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    logic                 nb_valid;
    logic [TIME_BITS-1:0] nb_time;
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign nb_valid = wb_valid;
      assign nb_time  = wb_time;
    end else begin : g_body
      assign nb_valid = cell_valid[k+1];
      assign nb_time  = cell_time[k+1];
    end
    ess_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .valid_i(nb_valid),
      .time_i (nb_time),
      .valid_o(cell_valid[k]),
      .time_o (cell_time[k])
    );
  end

  // head processor: slot cnt_q sits in cell 0 while scanning
  always_comb begin
    wb_valid = cell_valid[0];
    wb_time  = cell_time[0];
    hit_d    = hit_q;
    slot_d   = slot_q;
    rtime_d  = rtime_q;
    if (shift) begin
      case (act_q)
        ActAdd: begin
          if (!cell_valid[0] && !hit_q) begin
            wb_valid = 1'b1;
            wb_time  = etime_q;
            hit_d    = 1'b1;
            slot_d   = cnt_q;
            rtime_d  = etime_q;
          end
        end
        ActChange: begin
          if (id_match && cell_valid[0]) begin
            wb_time = etime_q;
            hit_d   = 1'b1;
            rtime_d = etime_q;
          end
        end
        ActRetire: begin
          if (id_match && cell_valid[0]) begin
            hit_d = 1'b1;
            if (intv_q == '0) begin
              wb_valid = 1'b0;
              rtime_d  = cell_time[0];
            end else begin
              wb_time = sum_t;
              rtime_d = sum_t;
            end
          end
        end
        ActQuery: begin
          if (cell_valid[0] && (!hit_q || (cell_time[0] < rtime_q))) begin
            hit_d   = 1'b1;
            slot_d  = cnt_q;
            rtime_d = cell_time[0];
          end
        end
        default: begin
          hit_d = hit_q;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rslot_d = rslot_q;
    rtout_d = rtout_q;
    found_d = found_q;
    sts_d   = sts_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StScan;
          cnt_d   = '0;
        end
      end
      StScan: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SlotW'(NUM_SLOTS - 1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        state_d = StIdle;
        done_d  = 1'b1;
        rslot_d = '0;
        rtout_d = '0;
        found_d = 1'b0;
        sts_d   = StsOk;
        case (act_q)
          ActAdd: begin
            if (hit_q) begin
              rslot_d = slot_ext[SlotIdW-1:0];
              rtout_d = rtime_ext[TimeFldW-1:0];
            end else begin
              sts_d = StsFull;
            end
          end
          ActQuery: begin
            if (hit_q && (rtime_q < dl_q)) begin
              rslot_d = slot_ext[SlotIdW-1:0];
              rtout_d = rtime_ext[TimeFldW-1:0];
              found_d = 1'b1;
            end
          end
          default: begin
            rslot_d = sid_q;
            if (hit_q) begin
              rtout_d = rtime_ext[TimeFldW-1:0];
            end else begin
              sts_d = StsInvalid;
            end
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      hit_q   <= accept ? 1'b0 : hit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    rtime_q <= rtime_d;
    rslot_q <= rslot_d;
    rtout_q <= rtout_d;
    found_q <= found_d;
    sts_q   <= sts_d;
    if (accept) begin
      act_q   <= action_i;
      sid_q   <= slot_id_i;
      etime_q <= etime_ext[TIME_BITS-1:0];
      intv_q  <= repeat_interval_i;
      dl_q    <= dl_ext[TIME_BITS-1:0];
    end
  end

  assign busy          = (state_q != StIdle);
  assign done_o        = done_q;
  assign result_slot_o = rslot_q;
  assign result_time_o = rtout_q;
  assign found_o       = found_q;
  assign status_o      = sts_q;

endmodule

// ===== hdl/ess_checker.sv =====
`include "event_slot_scheduler_core_macros.svh"

module ess_checker #(
  parameter int unsigned NUM_SLOTS = ess_pkg::NumSlotsDef
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic                          found_o,
  input logic [ess_pkg::StatusW-1:0]   status_o
);

  import ess_pkg::*;

  `ESS_ASSERT_IMPL(a_done_idle, done_o, !busy)
  `ESS_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done_o)
  `ESS_ASSERT_DLY(a_latency, start && !busy, NUM_SLOTS + 2, done_o)
  `ESS_ASSERT_IMPL(a_found_ok, done_o && found_o, status_o == StsOk)

endmodule

bind event_slot_scheduler_core ess_checker #(
  .NUM_SLOTS(NUM_SLOTS)
) u_ess_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .found_o (found_o),
  .status_o(status_o)
);
